@@ hdl/tte_pkg.sv @@
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types and constants for the timer table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tte_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int MAX_RESULTS = 16;

  localparam int OWN_W  = 8;
  localparam int SES_W  = 16;
  localparam int DUR_W  = 16;
  localparam int TIME_W = 32;

  // slot index, and a count that can hold the slot count itself
  localparam int IDX_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
  localparam int LEFT_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_ADD     = 2'd1,
    MODE_DEL     = 2'd2,
    MODE_RESTART = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_EXPIRY = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_ZERO_OK,
    ST_ZERO_EXP
  } state_e;

  typedef struct packed {
    mode_e              mode;
    logic [OWN_W-1:0]   owner;
    logic [SES_W-1:0]   session;
    logic [DUR_W-1:0]   duration;
    logic               periodic;
  } cmd_t;

  // one table entry as held in the slot RAM
  typedef struct packed {
    logic [OWN_W-1:0]   owner;
    logic [SES_W-1:0]   session;
    logic [TIME_W-1:0]  expire;
    logic               periodic;
    logic [DUR_W-1:0]   duration;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    kind_e              kind;
    logic [OWN_W-1:0]   owner;
    logic [SES_W-1:0]   session;
    status_e            status;
    logic               last;
  } res_t;

  typedef struct packed {
    logic vld;
    res_t res;
  } push_t;

endpackage

`default_nettype wire

@@ hdl/tte_if.sv @@
// ----------------------------------------------------------------------------
// tte_if
// Command and result channel interfaces (valid/ready, one word per handshake).
// ----------------------------------------------------------------------------
`default_nettype none

interface tte_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic [tte_pkg::OWN_W-1:0] owner;
  logic [tte_pkg::SES_W-1:0] session;
  logic [tte_pkg::DUR_W-1:0] duration;
  logic                      periodic;

  modport source (output valid, mode, owner, session, duration, periodic,
                  input ready);
  modport sink   (input valid, mode, owner, session, duration, periodic,
                  output ready);
endinterface

interface tte_res_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [tte_pkg::OWN_W-1:0] owner_out;
  logic [tte_pkg::SES_W-1:0] session_out;
  logic [1:0]                status;
  logic                      last;

  modport source (output valid, kind, owner_out, session_out, status, last,
                  input ready);
  modport sink   (input valid, kind, owner_out, session_out, status, last,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/tte_ram.sv @@
// ----------------------------------------------------------------------------
// tte_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/tte_ctrl.sv @@
// ----------------------------------------------------------------------------
// tte_ctrl
// Command sequencer: slot scan over the RAM, valid bits, tick counter, updates.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_ctrl import tte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tte_cmd_if.sink           cmd_i,
  input  logic              out_free_i,
  output push_t             push_o,
  output logic              ram_we_o,
  output logic [IDX_W-1:0]  ram_waddr_o,
  output logic [SLOT_W-1:0] ram_wdata_o,
  output logic [IDX_W-1:0]  ram_raddr_o,
  input  logic [SLOT_W-1:0] ram_rdata_i
);

  localparam int CAP_W = CNT_W + LEFT_W;

  state_e             state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [TIMER_SLOTS-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic               pipe_vld_q, pipe_vld_d;
  logic [IDX_W-1:0]   pipe_idx_q, pipe_idx_d;
  logic               found_q, found_d;
  logic               first_q, first_d;
  logic [LEFT_W-1:0]  left_q, left_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [TIME_W-1:0]  best_age_q, best_age_d;
  slot_t              best_ent_q, best_ent_d;
  logic [CNT_W-1:0]   due_cnt_q, due_cnt_d;

  slot_t              ent;
  logic               slot_v;
  logic [TIME_W-1:0]  age;
  logic               due;
  logic               hit;
  logic [CAP_W-1:0]   due_ext;
  logic [LEFT_W-1:0]  capped;
  logic [LEFT_W-1:0]  left_now;
  slot_t              new_ent;
  slot_t              rearm_ent;

  // scan compare on the word returned by the RAM
  assign ent    = slot_t'(ram_rdata_i);
  assign slot_v = valid_q[pipe_idx_q];
  assign age    = now_q - ent.expire;
  assign due    = slot_v && !age[TIME_W-1];
  assign hit    = slot_v && (ent.owner == cmd_q.owner) && (ent.session == cmd_q.session);

  assign due_ext  = CAP_W'(due_cnt_q);
  assign capped   = (due_ext > CAP_W'(MAX_RESULTS)) ? LEFT_W'(MAX_RESULTS)
                                                    : LEFT_W'(due_ext);
  assign left_now = first_q ? capped : left_q;

  always_comb begin
    new_ent          = '0;
    new_ent.owner    = cmd_q.owner;
    new_ent.session  = cmd_q.session;
    new_ent.expire   = now_q + TIME_W'(cmd_q.duration);
    new_ent.periodic = cmd_q.periodic;
    new_ent.duration = cmd_q.duration;
    rearm_ent        = best_ent_q;
    rearm_ent.expire = now_q + TIME_W'(best_ent_q.duration);
  end

  assign ram_raddr_o = rd_idx_q[IDX_W-1:0];
  assign cmd_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    now_d       = now_q;
    valid_d     = valid_q;
    rd_idx_d    = rd_idx_q;
    pipe_vld_d  = 1'b0;
    pipe_idx_d  = rd_idx_q[IDX_W-1:0];
    found_d     = found_q;
    first_d     = first_q;
    left_d      = left_q;
    best_idx_d  = best_idx_q;
    best_age_d  = best_age_q;
    best_ent_d  = best_ent_q;
    due_cnt_d   = due_cnt_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = best_idx_q;
    ram_wdata_o = SLOT_W'(rearm_ent);
    push_o      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d.mode     = mode_e'(cmd_i.mode);
          cmd_d.owner    = cmd_i.owner;
          cmd_d.session  = cmd_i.session;
          cmd_d.duration = cmd_i.duration;
          cmd_d.periodic = cmd_i.periodic;
          first_d        = 1'b1;
          if (mode_e'(cmd_i.mode) == MODE_TICK) begin
            now_d = now_q + TIME_W'(1);
          end
          if ((mode_e'(cmd_i.mode) == MODE_ADD) && (cmd_i.duration == '0)) begin
            state_d = ST_ZERO_OK;
          end else begin
            state_d    = ST_SCAN;
            rd_idx_d   = '0;
            found_d    = 1'b0;
            due_cnt_d  = '0;
            best_age_d = '0;
          end
        end
      end

      ST_SCAN: begin
        if (rd_idx_q != CNT_W'(TIMER_SLOTS)) begin
          rd_idx_d   = rd_idx_q + CNT_W'(1);
          pipe_vld_d = 1'b1;
        end else if (!pipe_vld_q) begin
          state_d = ST_ACT;
        end
        if (pipe_vld_q) begin
          unique case (cmd_q.mode)
            MODE_TICK: begin
              if (due) begin
                due_cnt_d = due_cnt_q + CNT_W'(1);
                // strictly older wins, so ties keep the lower slot
                if (!found_q || (age > best_age_q)) begin
                  found_d    = 1'b1;
                  best_idx_d = pipe_idx_q;
                  best_age_d = age;
                  best_ent_d = ent;
                end
              end
            end
            MODE_ADD: begin
              if (!slot_v && !found_q) begin
                found_d    = 1'b1;
                best_idx_d = pipe_idx_q;
              end
            end
            MODE_DEL, MODE_RESTART: begin
              if (hit && !found_q) begin
                found_d    = 1'b1;
                best_idx_d = pipe_idx_q;
                best_ent_d = ent;
              end
            end
          endcase
        end
      end

      ST_ACT: begin
        push_o.res.owner   = cmd_q.owner;
        push_o.res.session = cmd_q.session;
        push_o.res.kind    = KIND_STATUS;
        push_o.res.status  = found_q ? STAT_OK : STAT_NOT_FOUND;
        push_o.res.last    = 1'b1;
        unique case (cmd_q.mode)
          MODE_TICK: begin
            if (!found_q) begin
              state_d = ST_IDLE;
            end else if (out_free_i) begin
              push_o.vld         = 1'b1;
              push_o.res.kind    = KIND_EXPIRY;
              push_o.res.owner   = best_ent_q.owner;
              push_o.res.session = best_ent_q.session;
              push_o.res.status  = STAT_OK;
              push_o.res.last    = (left_now == LEFT_W'(1));
              if (best_ent_q.periodic) begin
                ram_we_o = 1'b1;
              end else begin
                valid_d[best_idx_q] = 1'b0;
              end
              left_d  = left_now - LEFT_W'(1);
              first_d = 1'b0;
              if (left_now == LEFT_W'(1)) begin
                state_d = ST_IDLE;
              end else begin
                state_d    = ST_SCAN;
                rd_idx_d   = '0;
                found_d    = 1'b0;
                best_age_d = '0;
              end
            end
          end
          MODE_ADD: begin
            push_o.res.status = found_q ? STAT_OK : STAT_FULL;
            if (out_free_i) begin
              push_o.vld = 1'b1;
              state_d    = ST_IDLE;
              if (found_q) begin
                ram_we_o            = 1'b1;
                ram_wdata_o         = SLOT_W'(new_ent);
                valid_d[best_idx_q] = 1'b1;
              end
            end
          end
          MODE_DEL: begin
            if (out_free_i) begin
              push_o.vld = 1'b1;
              state_d    = ST_IDLE;
              if (found_q) begin
                valid_d[best_idx_q] = 1'b0;
              end
            end
          end
          MODE_RESTART: begin
            if (out_free_i) begin
              push_o.vld = 1'b1;
              state_d    = ST_IDLE;
              ram_we_o   = found_q;
            end
          end
        endcase
      end

      ST_ZERO_OK: begin
        push_o.res.kind    = KIND_STATUS;
        push_o.res.owner   = cmd_q.owner;
        push_o.res.session = cmd_q.session;
        push_o.res.status  = STAT_OK;
        push_o.res.last    = 1'b0;
        if (out_free_i) begin
          push_o.vld = 1'b1;
          state_d    = ST_ZERO_EXP;
        end
      end

      ST_ZERO_EXP: begin
        push_o.res.kind    = KIND_EXPIRY;
        push_o.res.owner   = cmd_q.owner;
        push_o.res.session = cmd_q.session;
        push_o.res.status  = STAT_OK;
        push_o.res.last    = 1'b1;
        if (out_free_i) begin
          push_o.vld = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      now_q      <= '0;
      valid_q    <= '0;
      rd_idx_q   <= '0;
      pipe_vld_q <= 1'b0;
      found_q    <= 1'b0;
      first_q    <= 1'b0;
      left_q     <= '0;
    end else begin
      state_q    <= state_d;
      now_q      <= now_d;
      valid_q    <= valid_d;
      rd_idx_q   <= rd_idx_d;
      pipe_vld_q <= pipe_vld_d;
      found_q    <= found_d;
      first_q    <= first_d;
      left_q     <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    pipe_idx_q <= pipe_idx_d;
    best_idx_q <= best_idx_d;
    best_age_q <= best_age_d;
    best_ent_q <= best_ent_d;
    due_cnt_q  <= due_cnt_d;
  end

endmodule

`default_nettype wire

@@ hdl/tte_out.sv @@
// ----------------------------------------------------------------------------
// tte_out
// Output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_out import tte_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  push_t    push_i,
  output logic     free_o,
  tte_res_if.source res_o
);

  logic out_vld_q, out_vld_d;
  res_t res_q, res_d;

  // a new word may be loaded when empty or when the held one leaves now
  assign free_o = !out_vld_q || res_o.ready;

  always_comb begin
    out_vld_d = out_vld_q;
    res_d     = res_q;
    if (push_i.vld) begin
      out_vld_d = 1'b1;
      res_d     = push_i.res;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.kind        = res_q.kind;
  assign res_o.owner_out   = res_q.owner;
  assign res_o.session_out = res_q.session;
  assign res_o.status      = res_q.status;
  assign res_o.last        = res_q.last;

endmodule

`default_nettype wire

@@ hdl/timer_table_engine.sv @@
// ----------------------------------------------------------------------------
// timer_table_engine
// Table of armed one-shot and periodic timers with a 32-bit tick counter.
// ----------------------------------------------------------------------------
// Takes one command word at a time (tick, add, delete, restart) and answers
// with result words: one status word per add/delete/restart, and zero or
// more expiry words per tick, the final word of each command flagged by
// last. Timer entries live in one RAM read a slot per cycle; the valid bits
// are flip-flops cleared by reset, so no clearing pass is needed. Every
// command but an add of zero duration walks the whole table (TIMER_SLOTS,
// 16 here) through the single RAM read port and then acts on what it found.
// A tick firing k timers makes max(1,k) scans, one per event. An add of
// zero duration needs no scan. Stalls on the result side can hold the
// sequencer whenever it has a word to emit.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_table_engine import tte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tte_cmd_if.sink   cmd_i,
  tte_res_if.source res_o
);

  push_t             push;
  logic              out_free;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;

  // sequencer: scan, due/match selection, slot updates, counter
  tte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .out_free_i  (out_free),
    .push_o      (push),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // owner, session, expiry, period flag and duration of each slot
  tte_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TIMER_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result word register; the sequencer waits on it only when it must emit
  tte_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .free_o (out_free),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

@@ hdl/tte_checker.sv @@
// ----------------------------------------------------------------------------
// tte_checker
// Port-level assertions for the timer table engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_checker import tte_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cmd_valid_i,
  input logic             cmd_ready_i,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input logic             res_kind_i,
  input logic [OWN_W-1:0] res_owner_i,
  input logic [SES_W-1:0] res_session_i,
  input logic [1:0]       res_status_i,
  input logic             res_last_i
);

  // stalled result word holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_kind_i)
      && $stable(res_owner_i) && $stable(res_session_i)
      && $stable(res_status_i) && $stable(res_last_i))
    else $error("result word changed under stall");

  // one command at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command taken while busy");

  a_exp_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == KIND_EXPIRY) |-> (res_status_i == STAT_OK))
    else $error("expiry word with error status");

  // an error status comes only on a final status word
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_status_i != STAT_OK) |-> res_last_i
      && (res_kind_i == KIND_STATUS))
    else $error("error status not a final status word");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_status_i == STAT_OK) || (res_status_i == STAT_NOT_FOUND)
      || (res_status_i == STAT_FULL))
    else $error("unknown status code");

endmodule

bind timer_table_engine tte_checker u_tte_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cmd_valid_i   (cmd_i.valid),
  .cmd_ready_i   (cmd_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_kind_i    (res_o.kind),
  .res_owner_i   (res_o.owner_out),
  .res_session_i (res_o.session_out),
  .res_status_i  (res_o.status),
  .res_last_i    (res_o.last)
);

`default_nettype wire

@@ tb/timer_table_engine_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_table_engine_test
// Self-checking bench for the timer table engine.
// ----------------------------------------------------------------------------
// A queue of command words is filled up front: a short directed run over the
// corner cases, then random sequences (table fills, tick runs, deletes and
// restarts of added keys, zero-length adds, noise). A clocked driver offers
// them in bursts. A clocked monitor predicts the result words of each
// accepted command from a private copy of the timer table and checks every
// result word against the oldest prediction. The result side stalls on a
// changing pattern, with one long hold-off while commands keep coming.
// ----------------------------------------------------------------------------

module timer_table_engine_test;
  import tte_pkg::*;

  localparam int RANDOM_ITEMS = 130;
  localparam int IDLE_SETTLE  = 40;
  localparam int END_SETTLE   = 400;   // longer than a tick firing a full table
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AFTER   = 30;    // result words checked before the hold-off

  typedef struct packed {
    logic wait_idle;  // hold back until every expected word has come
    cmd_t cmd;
  } queued_cmd_t;

  logic clk_i;
  logic rst_ni;

  tte_cmd_if cmd_ch ();
  tte_res_if res_ch ();

  timer_table_engine uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch.sink),
    .res_o  (res_ch.source)
  );

  // --------------------------------------------------------------------------
  // Shadow timer table
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0] now_ticks;
  logic              slot_live  [TIMER_SLOTS];
  logic [OWN_W-1:0]  slot_own   [TIMER_SLOTS];
  logic [SES_W-1:0]  slot_ses   [TIMER_SLOTS];
  logic [TIME_W-1:0] slot_due   [TIMER_SLOTS];
  logic              slot_rearm [TIMER_SLOTS];
  logic [DUR_W-1:0]  slot_len   [TIMER_SLOTS];

  queued_cmd_t cmd_queue[$];
  res_t        expected_words[$];
  logic [23:0] key_pool[$];     // {owner, session} of recent adds, at most 48 kept

  int mismatches    = 0;
  int words_checked = 0;
  int cmd_count [4] = '{0, 0, 0, 0};
  int expiries      = 0;
  int full_answers  = 0;
  int missing       = 0;

  // driver and receiver state
  logic cmd_taken    = 1'b0;
  logic offering     = 1'b0;
  logic idle_cleared = 1'b0;
  int   gap_left     = 0;
  int   burst_left   = 4;
  int   settle_left  = IDLE_SETTLE;
  int   hold_left    = 0;
  logic hold_done    = 1'b0;
  int   stall_phase  = 0;
  logic [7:0] ready_pattern = 8'hFF;

  // Works out the result words of one command and moves the shadow table on.
  task automatic apply_timer_cmd(input cmd_t c);
    res_t              words[$];
    res_t              w;
    int                hit;
    int                best;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] best_age;
    cmd_count[c.mode]++;
    w.kind    = KIND_STATUS;
    w.owner   = c.owner;
    w.session = c.session;
    w.status  = STAT_OK;
    w.last    = 1'b1;
    hit       = -1;
    case (c.mode)
      MODE_TICK: begin
        now_ticks = now_ticks + 1;
        while (words.size() < MAX_RESULTS) begin
          best     = -1;
          best_age = '0;
          for (int s = 0; s < TIMER_SLOTS; s++) begin
            if (slot_live[s]) begin
              age = now_ticks - slot_due[s];
              // due when the age is below half the counter range;
              // strict compare keeps ties on the lower slot
              if (!age[TIME_W-1] && (best < 0 || age > best_age)) begin
                best     = s;
                best_age = age;
              end
            end
          end
          if (best < 0) break;
          w.kind    = KIND_EXPIRY;
          w.owner   = slot_own[best];
          w.session = slot_ses[best];
          w.status  = STAT_OK;
          w.last    = 1'b0;
          words.push_back(w);
          expiries++;
          if (slot_rearm[best]) slot_due[best] = now_ticks + TIME_W'(slot_len[best]);
          else slot_live[best] = 1'b0;
        end
        if (words.size() > 0) begin
          w      = words.pop_back();
          w.last = 1'b1;
          words.push_back(w);
        end
      end
      MODE_ADD: begin
        if (c.duration == '0) begin
          // fires at once, no slot taken
          w.last = 1'b0;
          words.push_back(w);
          w.kind = KIND_EXPIRY;
          w.last = 1'b1;
          words.push_back(w);
          expiries++;
        end else begin
          for (int s = 0; s < TIMER_SLOTS; s++)
            if (!slot_live[s] && hit < 0) hit = s;
          if (hit < 0) begin
            w.status = STAT_FULL;
            full_answers++;
          end else begin
            slot_live[hit]  = 1'b1;
            slot_own[hit]   = c.owner;
            slot_ses[hit]   = c.session;
            slot_len[hit]   = c.duration;
            slot_rearm[hit] = c.periodic;
            slot_due[hit]   = now_ticks + TIME_W'(c.duration);
          end
          words.push_back(w);
        end
      end
      default: begin  // delete or restart, lowest matching slot
        for (int s = 0; s < TIMER_SLOTS; s++)
          if (slot_live[s] && slot_own[s] == c.owner && slot_ses[s] == c.session
              && hit < 0)
            hit = s;
        if (hit < 0) begin
          w.status = STAT_NOT_FOUND;
          missing++;
        end else if (c.mode == MODE_DEL) begin
          slot_live[hit] = 1'b0;
        end else begin
          slot_due[hit] = now_ticks + TIME_W'(slot_len[hit]);
        end
        words.push_back(w);
      end
    endcase
    foreach (words[k]) expected_words.push_back(words[k]);
  endtask

  function automatic void push_cmd(input mode_e m, input logic [OWN_W-1:0] own,
                                   input logic [SES_W-1:0] ses,
                                   input logic [DUR_W-1:0] dur, input logic per,
                                   input logic idle);
    queued_cmd_t q;
    q.wait_idle    = idle;
    q.cmd.mode     = m;
    q.cmd.owner    = own;
    q.cmd.session  = ses;
    q.cmd.duration = dur;
    q.cmd.periodic = per;
    cmd_queue.push_back(q);
    if (m == MODE_ADD) key_pool.push_back({own, ses});
    if (key_pool.size() > 48) void'(key_pool.pop_front());
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and known input levels from time zero
  // --------------------------------------------------------------------------
  initial begin
    clk_i           = 1'b0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.mode     = MODE_TICK;
    cmd_ch.owner    = '0;
    cmd_ch.session  = '0;
    cmd_ch.duration = '0;
    cmd_ch.periodic = 1'b0;
    res_ch.ready    = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    now_ticks = '0;
    for (int s = 0; s < TIMER_SLOTS; s++) begin
      slot_live[s]  = 1'b0;
      slot_own[s]   = '0;
      slot_ses[s]   = '0;
      slot_due[s]   = '0;
      slot_rearm[s] = 1'b0;
      slot_len[s]   = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Command driver: bursts with random gaps, honours wait_idle
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_cmd
    queued_cmd_t head;
    if (rst_ni) begin
      if (cmd_taken) begin
        cmd_taken = 1'b0;
        offering  = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_queue.size() > 0 && cmd_queue[0].wait_idle && !idle_cleared) begin
          // pause until the engine has drained, then let a slow tick finish
          if (expected_words.size() != 0) settle_left = IDLE_SETTLE;
          else if (settle_left > 0) settle_left--;
          else begin
            idle_cleared = 1'b1;
            settle_left  = IDLE_SETTLE;
          end
        end
        if (gap_left == 0 && cmd_queue.size() > 0
            && (!cmd_queue[0].wait_idle || idle_cleared)) begin
          head            = cmd_queue.pop_front();
          idle_cleared    = 1'b0;
          offering        = 1'b1;
          cmd_ch.mode     <= head.cmd.mode;
          cmd_ch.owner    <= head.cmd.owner;
          cmd_ch.session  <= head.cmd.session;
          cmd_ch.duration <= head.cmd.duration;
          cmd_ch.periodic <= head.cmd.periodic;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            // now and then a long gap-free run
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
            gap_left   = (hold_left > 0) ? 0 : $urandom_range(0, 24);
          end
        end
      end
      cmd_ch.valid <= offering;
    end
  end

  // --------------------------------------------------------------------------
  // Result-side ready: shifting stall pattern plus one long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_ready
    if (rst_ni) begin
      stall_phase++;
      if (stall_phase == 48) begin
        stall_phase   = 0;
        ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      end
      if (!hold_done && words_checked >= HOLD_AFTER) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) hold_left--;
      res_ch.ready <= (hold_left == 0) && ready_pattern[stall_phase % 8];
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each accepted command, check each accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    cmd_t c;
    res_t exp_w;
    if (rst_ni) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        c.mode     = mode_e'(cmd_ch.mode);
        c.owner    = cmd_ch.owner;
        c.session  = cmd_ch.session;
        c.duration = cmd_ch.duration;
        c.periodic = cmd_ch.periodic;
        apply_timer_cmd(c);
        cmd_taken = 1'b1;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word kind %0d owner %h session %h status %0d last %0d",
                   $time, res_ch.kind, res_ch.owner_out, res_ch.session_out,
                   res_ch.status, res_ch.last);
        end else begin
          exp_w = expected_words.pop_front();
          words_checked++;
          if (res_ch.kind !== exp_w.kind || res_ch.owner_out !== exp_w.owner
              || res_ch.session_out !== exp_w.session || res_ch.status !== exp_w.status
              || res_ch.last !== exp_w.last) begin
            mismatches++;
            $display("%0t: mismatch, expected kind %0d owner %h session %h status %0d last %0d",
                     $time, exp_w.kind, exp_w.owner, exp_w.session, exp_w.status,
                     exp_w.last);
            $display("%0t:           actual kind %0d owner %h session %h status %0d last %0d",
                     $time, res_ch.kind, res_ch.owner_out, res_ch.session_out,
                     res_ch.status, res_ch.last);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int               first_random;
    int               pick;
    int               len;
    int               idx;
    logic             idle;
    logic [23:0]      key;
    mode_e            m;

    // directed: empty tick, zero-length add, one-shot fire, misses
    push_cmd(MODE_TICK,    8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
    push_cmd(MODE_ADD,     8'hFF, 16'hFFFF, 16'h0000, 1'b1, 1'b0);
    push_cmd(MODE_ADD,     8'h00, 16'h0000, 16'h0001, 1'b0, 1'b0);
    push_cmd(MODE_TICK,    8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    push_cmd(MODE_DEL,     8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
    push_cmd(MODE_RESTART, 8'h12, 16'h3456, 16'h0000, 1'b0, 1'b0);
    // longest duration, duplicate keys, and an expiry tie
    push_cmd(MODE_ADD,     8'hA5, 16'h5A5A, 16'hFFFF, 1'b1, 1'b0);
    push_cmd(MODE_ADD,     8'h01, 16'h0001, 16'h0002, 1'b1, 1'b0);
    push_cmd(MODE_ADD,     8'h01, 16'h0001, 16'h0003, 1'b0, 1'b0);
    push_cmd(MODE_ADD,     8'h02, 16'h0007, 16'h0002, 1'b0, 1'b0);
    push_cmd(MODE_RESTART, 8'h01, 16'h0001, 16'h0000, 1'b0, 1'b0);
    push_cmd(MODE_TICK,    8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
    push_cmd(MODE_TICK,    8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
    push_cmd(MODE_TICK,    8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
    push_cmd(MODE_TICK,    8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0);
    push_cmd(MODE_DEL,     8'h01, 16'h0001, 16'h0000, 1'b0, 1'b0);
    push_cmd(MODE_RESTART, 8'hA5, 16'h5A5A, 16'h1234, 1'b1, 1'b0);
    push_cmd(MODE_DEL,     8'hA5, 16'h5A5A, 16'h0000, 1'b0, 1'b0);
    push_cmd(MODE_ADD,     8'h5A, 16'hA5A5, 16'h8000, 1'b0, 1'b0);
    push_cmd(MODE_DEL,     8'h5A, 16'hA5A5, 16'h0000, 1'b0, 1'b0);
    key_pool.delete();

    // random sequences; the first one fills the table past full
    first_random = cmd_queue.size();
    while (cmd_queue.size() - first_random < RANDOM_ITEMS) begin
      pick = (cmd_queue.size() == first_random) ? 0 : $urandom_range(0, 99);
      idle = (cmd_queue.size() == first_random) || ($urandom_range(0, 19) == 0);
      if (pick < 20) begin
        len = (pick == 0) ? TIMER_SLOTS + 1 : $urandom_range(4, TIMER_SLOTS + 1);
        for (int k = 0; k < len; k++) begin
          push_cmd(MODE_ADD, 8'($urandom_range(0, 7)), 16'($urandom_range(0, 5)),
                   16'($urandom_range(1, 6)), 1'($urandom), idle);
          idle = 1'b0;
        end
      end else if (pick < 55) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          push_cmd(MODE_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                   idle);
          idle = 1'b0;
        end
      end else if (pick < 78) begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          m = ($urandom_range(0, 1) == 0) ? MODE_DEL : MODE_RESTART;
          if (key_pool.size() > 0 && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, key_pool.size() - 1);
            key = key_pool[idx];
            if (m == MODE_DEL) key_pool.delete(idx);
          end else begin
            key = {8'($urandom_range(0, 7)), 16'($urandom_range(0, 5))};
          end
          push_cmd(m, key[23:16], key[15:0], 16'($urandom), 1'($urandom), idle);
          idle = 1'b0;
        end
      end else if (pick < 88) begin
        // noise: any mode, any field value
        push_cmd(mode_e'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                 16'($urandom), 1'($urandom), idle);
      end else begin
        push_cmd(MODE_ADD, 8'($urandom), 16'($urandom),
                 ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom_range(1, 40)),
                 1'($urandom), idle);
      end
    end

    while (cmd_queue.size() != 0 || offering) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (END_SETTLE) @(posedge clk_i);

    $display("Commands: %0d ticks, %0d adds, %0d deletes, %0d restarts; %0d words checked",
             cmd_count[MODE_TICK], cmd_count[MODE_ADD], cmd_count[MODE_DEL],
             cmd_count[MODE_RESTART], words_checked);
    $display("Answers: %0d expiries, %0d table-full, %0d not-found; %0d mismatches",
             expiries, full_answers, missing, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Timeout with %0d words still expected", expected_words.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tte_pkg.sv
hdl/tte_if.sv
hdl/tte_ram.sv
hdl/tte_ctrl.sv
hdl/tte_out.sv
hdl/timer_table_engine.sv
hdl/tte_checker.sv
tb/timer_table_engine_test.sv
